/* sv/stl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package stl_pkg;

  typedef enum logic [1:0] {
    ACT_ISSUE   = 2'd0,
    ACT_RESOLVE = 2'd1,
    ACT_REVOKE  = 2'd2,
    ACT_NONE    = 2'd3
  } stl_action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_CLOCK    = 3'd2,
    ST_DENIED   = 3'd3,
    ST_BUSY     = 3'd4,
    ST_NOTFOUND = 3'd5
  } stl_status_t;

  localparam logic [1:0] CFG_TABLE_LIMIT = 2'd0;
  localparam logic [1:0] CFG_OWNER_LIMIT = 2'd1;
  localparam logic [1:0] CFG_LIFETIME    = 2'd2;

  localparam int KEY_W   = 64;
  localparam int OWNER_W = 32;
  localparam int CSRF_W  = 64;
  localparam int LIM_W   = 7;
  localparam int LIFE_W  = 17;
  localparam int CFG_W   = 17;

  typedef enum logic [14:0] {
    S_IDLE    = 15'h0001,
    S_CHECK   = 15'h0002,
    S_P1      = 15'h0004,
    S_P1END   = 15'h0008,
    S_LRU     = 15'h0010,
    S_LRUEND  = 15'h0020,
    S_SEQ     = 15'h0040,
    S_MINS    = 15'h0080,
    S_MINSEND = 15'h0100,
    S_RENORM  = 15'h0200,
    S_FIND    = 15'h0400,
    S_FINDEND = 15'h0800,
    S_RDSLOT  = 15'h1000,
    S_RDWAIT  = 15'h2000,
    S_FIN     = 15'h4000
  } stl_state_t;

endpackage
`default_nettype wire

/* sv/stl_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module stl_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic                 re,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

/* sv/session_table_ttl_lru_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// one word in, one word out; items are handled one at a time
// issue: up to five table passes (prune/owner, lru, min stamp, renormalise,
// key search); two or three passes typical
// resolve/revoke: one key search pass; resolve adds the min stamp and
// renormalise passes when the sequence counter saturates
// reset clears valid bits, sequence counter, handshake state and config to defaults
module session_table_ttl_lru_unit #(
  parameter int TABLE_DEPTH = 64,
  parameter int SEQ_WIDTH   = 32,
  parameter int TIME_WIDTH  = 40
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [stl_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   action,
  input  wire logic [stl_pkg::KEY_W-1:0]    session_key,
  input  wire logic [stl_pkg::OWNER_W-1:0]  owner_id,
  input  wire logic [TIME_WIDTH-1:0]        current_time,
  input  wire logic [TIME_WIDTH-1:0]        credential_expiry,
  input  wire logic [stl_pkg::CSRF_W-1:0]   token_value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [2:0]                        status,
  output logic [stl_pkg::OWNER_W-1:0]       owner_out,
  output logic [stl_pkg::CSRF_W-1:0]        csrf_out,
  output logic [TIME_WIDTH-1:0]             expiry_out
);
  import stl_pkg::*;

  localparam int IDXW = $clog2(TABLE_DEPTH);
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);
  localparam int LW   = (CNTW > LIM_W) ? CNTW : LIM_W;
  localparam int RW   = KEY_W + OWNER_W + CSRF_W + TIME_WIDTH + 2 * SEQ_WIDTH;
  localparam logic [IDXW:0]           DEPTH_C = (IDXW + 1)'(TABLE_DEPTH);
  localparam logic [IDXW-1:0]         LAST_C  = IDXW'(TABLE_DEPTH - 1);
  localparam logic [LW-1:0]           DEPTH_L = LW'(TABLE_DEPTH);
  localparam logic [SEQ_WIDTH-1:0]    SEQ_MAX = '1;
  localparam logic [TIME_WIDTH-1:0]   TIME_MAX = '1;

  stl_state_t st;

  logic [LIM_W-1:0]  table_limit, owner_limit;
  logic [LIFE_W-1:0] lifetime;

  logic [TABLE_DEPTH-1:0] vld;
  logic [SEQ_WIDTH-1:0]   seq_ctr, seq_val;

  // captured word
  logic [1:0]            c_act;
  logic [KEY_W-1:0]      c_key;
  logic [OWNER_W-1:0]    c_owner;
  logic [TIME_WIDTH-1:0] c_now, c_cred, c_exp;
  logic [CSRF_W-1:0]     c_csrf;

  // scan control
  logic [IDXW:0]   scan_addr;
  logic            proc_v;
  logic [IDXW-1:0] proc_idx;
  logic            in_scan, rd_scan, last_proc;

  // accumulators
  logic [CNTW-1:0]      cnt_all, cnt_own;
  logic                 opick_v, lpick_v, any_v, fk_v, ff_v;
  logic [IDXW-1:0]      opick, lpick, fk_idx, ff_idx;
  logic [SEQ_WIDTH-1:0] omin, lmin, smin;
  logic [OWNER_W-1:0]   f_owner;
  logic [CSRF_W-1:0]    f_csrf;
  logic [TIME_WIDTH-1:0] f_exp;

  // result staging
  logic [2:0]            r_status;
  logic [OWNER_W-1:0]    r_owner;
  logic [CSRF_W-1:0]     r_csrf;
  logic [TIME_WIDTH-1:0] r_exp;

  // memory
  logic            m_we, m_re;
  logic [IDXW-1:0] m_waddr, m_raddr;
  logic [RW-1:0]   m_wdata, m_rdata;

  logic [KEY_W-1:0]      d_key;
  logic [OWNER_W-1:0]    d_owner;
  logic [CSRF_W-1:0]     d_csrf;
  logic [TIME_WIDTH-1:0] d_exp;
  logic [SEQ_WIDTH-1:0]  d_iss, d_lru;

  logic                  p_vld, own_full, tbl_full;
  logic [LW-1:0]         cap, cnt_left;
  logic [TIME_WIDTH-1:0] life_ext, exp_calc;
  stl_state_t            post_seq;

  assign {d_key, d_owner, d_csrf, d_exp, d_iss, d_lru} = m_rdata;

  assign in_stall  = (st != S_IDLE);
  assign in_scan   = (st == S_P1) || (st == S_LRU) || (st == S_MINS) ||
                     (st == S_RENORM) || (st == S_FIND);
  assign rd_scan   = in_scan && (scan_addr < DEPTH_C);
  assign last_proc = proc_v && (proc_idx == LAST_C);
  assign p_vld     = vld[proc_idx];

  assign life_ext = TIME_WIDTH'(lifetime);
  assign exp_calc = ((c_now + life_ext) < c_cred) ? (c_now + life_ext) : c_cred;
  assign cap      = (LW'(table_limit) < DEPTH_L) ? LW'(table_limit) : DEPTH_L;
  assign own_full = opick_v && (LW'(cnt_own) >= LW'(owner_limit));
  assign cnt_left = LW'(cnt_all) - (own_full ? LW'(1) : LW'(0));
  assign tbl_full = cnt_left >= cap;
  assign post_seq = (c_act == ACT_ISSUE) ? S_FIND : S_RDSLOT;

  always_comb begin
    m_re    = rd_scan || (st == S_RDSLOT);
    m_raddr = (st == S_RDSLOT) ? fk_idx : scan_addr[IDXW-1:0];
    m_we    = 1'b0;
    m_waddr = proc_idx;
    m_wdata = {d_key, d_owner, d_csrf, d_exp, d_iss - smin, d_lru - smin};
    if (st == S_RENORM && proc_v && p_vld) begin
      m_we = 1'b1;
    end else if (st == S_FINDEND && c_act == ACT_ISSUE && (fk_v || ff_v)) begin
      m_we    = 1'b1;
      m_waddr = fk_v ? fk_idx : ff_idx;
      m_wdata = {c_key, c_owner, c_csrf, c_exp, seq_val, seq_val};
    end else if (st == S_RDWAIT) begin
      m_we    = 1'b1;
      m_waddr = fk_idx;
      m_wdata = {d_key, d_owner, d_csrf, d_exp, d_iss, seq_val};
    end
  end

  stl_ram #(.W(RW), .D(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .re    (m_re),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= S_IDLE;
      vld         <= '0;
      seq_ctr     <= '0;
      table_limit <= LIM_W'(64);
      owner_limit <= LIM_W'(4);
      lifetime    <= LIFE_W'(3600);
      out_valid   <= 1'b0;
      proc_v      <= 1'b0;
      scan_addr   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TABLE_LIMIT: table_limit <= cfg_data[LIM_W-1:0];
          CFG_OWNER_LIMIT: owner_limit <= cfg_data[LIM_W-1:0];
          CFG_LIFETIME:    lifetime    <= cfg_data[LIFE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall && st != S_FIN) begin
        out_valid <= 1'b0;
      end
      if (rd_scan) begin
        scan_addr <= scan_addr + 1'b1;
      end
      proc_v   <= rd_scan;
      proc_idx <= scan_addr[IDXW-1:0];

      unique case (st)
        S_IDLE: begin
          if (in_valid) begin
            c_act   <= action;
            c_key   <= session_key;
            c_owner <= owner_id;
            c_now   <= current_time;
            c_cred  <= credential_expiry;
            c_csrf  <= token_value;
            st      <= S_CHECK;
          end
        end
        S_CHECK: begin
          r_owner   <= '0;
          r_csrf    <= '0;
          r_exp     <= '0;
          scan_addr <= '0;
          cnt_all   <= '0;
          cnt_own   <= '0;
          opick_v   <= 1'b0;
          lpick_v   <= 1'b0;
          any_v     <= 1'b0;
          fk_v      <= 1'b0;
          ff_v      <= 1'b0;
          case (c_act)
            ACT_ISSUE: begin
              if (c_cred == '0) begin
                r_status <= ST_INVALID;
                st       <= S_FIN;
              end else if (c_now == '0 || c_now > TIME_MAX - life_ext) begin
                r_status <= ST_CLOCK;
                st       <= S_FIN;
              end else if (c_cred <= c_now) begin
                r_status <= ST_DENIED;
                st       <= S_FIN;
              end else begin
                r_status <= ST_OK;
                c_exp    <= exp_calc;
                st       <= S_P1;
              end
            end
            ACT_RESOLVE: begin
              if (c_now == '0) begin
                r_status <= ST_CLOCK;
                st       <= S_FIN;
              end else begin
                r_status <= ST_OK;
                st       <= S_FIND;
              end
            end
            ACT_REVOKE: begin
              r_status <= ST_OK;
              st       <= S_FIND;
            end
            default: begin
              r_status <= ST_INVALID;
              st       <= S_FIN;
            end
          endcase
        end
        // prune expired entries, count owner's entries and all live ones
        S_P1: begin
          if (proc_v && p_vld) begin
            if (c_now >= d_exp) begin
              vld[proc_idx] <= 1'b0;
            end else begin
              cnt_all <= cnt_all + 1'b1;
              if (d_owner == c_owner) begin
                cnt_own <= cnt_own + 1'b1;
                if (!opick_v || d_iss < omin) begin
                  opick_v <= 1'b1;
                  opick   <= proc_idx;
                  omin    <= d_iss;
                end
              end
            end
          end
          if (last_proc) st <= S_P1END;
        end
        S_P1END: begin
          if (own_full) vld[opick] <= 1'b0;
          scan_addr <= '0;
          st        <= tbl_full ? S_LRU : S_SEQ;
        end
        S_LRU: begin
          if (proc_v && p_vld && (!lpick_v || d_lru < lmin)) begin
            lpick_v <= 1'b1;
            lpick   <= proc_idx;
            lmin    <= d_lru;
          end
          if (last_proc) st <= S_LRUEND;
        end
        S_LRUEND: begin
          if (!lpick_v) begin
            r_status <= ST_BUSY;
            st       <= S_FIN;
          end else begin
            vld[lpick] <= 1'b0;
            st         <= S_SEQ;
          end
        end
        S_SEQ: begin
          scan_addr <= '0;
          if (seq_ctr == SEQ_MAX) begin
            st <= S_MINS;
          end else begin
            seq_ctr <= seq_ctr + 1'b1;
            seq_val <= seq_ctr + 1'b1;
            st      <= post_seq;
          end
        end
        S_MINS: begin
          if (proc_v && p_vld && (!any_v || d_iss < smin)) begin
            any_v <= 1'b1;
            smin  <= d_iss;
          end
          if (last_proc) st <= S_MINSEND;
        end
        S_MINSEND: begin
          scan_addr <= '0;
          if (!any_v) begin
            seq_ctr <= SEQ_WIDTH'(1);
            seq_val <= SEQ_WIDTH'(1);
            st      <= post_seq;
          end else begin
            st <= S_RENORM;
          end
        end
        // write back every live entry with both stamps lowered by the minimum
        S_RENORM: begin
          if (last_proc) begin
            seq_ctr   <= seq_ctr - smin + 1'b1;
            seq_val   <= seq_ctr - smin + 1'b1;
            scan_addr <= '0;
            st        <= post_seq;
          end
        end
        S_FIND: begin
          if (proc_v) begin
            if (p_vld && d_key == c_key && !fk_v) begin
              fk_v    <= 1'b1;
              fk_idx  <= proc_idx;
              f_owner <= d_owner;
              f_csrf  <= d_csrf;
              f_exp   <= d_exp;
            end
            if (!p_vld && !ff_v) begin
              ff_v   <= 1'b1;
              ff_idx <= proc_idx;
            end
          end
          if (last_proc) st <= S_FINDEND;
        end
        S_FINDEND: begin
          st <= S_FIN;
          case (c_act)
            ACT_ISSUE: begin
              if (fk_v || ff_v) begin
                vld[fk_v ? fk_idx : ff_idx] <= 1'b1;
                r_exp <= c_exp;
              end else begin
                r_status <= ST_BUSY;
              end
            end
            ACT_RESOLVE: begin
              if (!fk_v) begin
                r_status <= ST_DENIED;
              end else if (c_now >= f_exp) begin
                vld[fk_idx] <= 1'b0;
                r_status    <= ST_DENIED;
              end else begin
                st <= S_SEQ;
              end
            end
            default: begin
              if (fk_v) vld[fk_idx] <= 1'b0;
              else r_status <= ST_NOTFOUND;
            end
          endcase
        end
        S_RDSLOT: st <= S_RDWAIT;
        S_RDWAIT: begin
          r_owner <= f_owner;
          r_csrf  <= f_csrf;
          r_exp   <= f_exp;
          st      <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            status     <= r_status;
            owner_out  <= r_owner;
            csrf_out   <= r_csrf;
            expiry_out <= r_exp;
            st         <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (st == S_CHECK))
    else $error("accepted word did not start processing");

  a_seq_idle_stable: assert property (@(posedge clk) disable iff (rst)
    (st == S_IDLE) |=> $stable(seq_ctr))
    else $error("sequence counter moved while idle");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(st == S_FIN))
    else $error("result word raised outside finish");

endmodule
`default_nettype wire
